FILE: rtl/core/qrt_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and arithmetic helpers for the quaternion rigid transform.
// No dependencies; every other file in rtl/core imports this package.
package qrt_pkg;

  // Fixed formats: coordinates Q16.16, quaternion Q1.16
  localparam int CW  = 32;          // coordinate width
  localparam int QF  = 16;          // quaternion fraction bits
  localparam int QW  = QF + 2;      // quaternion register width
  localparam int QNW = QW + 1;      // quaternion after conjugation (negating -2^17)
  localparam int DW  = CW + 1;      // point-to-local difference, exact
  localparam int P1W = QNW + DW;    // first cross product term
  localparam int S1W = P1W + 1;     // difference of two terms
  localparam int UW  = S1W - QF;    // rounded u x v component
  localparam int P2W = QNW + UW;    // second stage product term
  localparam int S2W = P2W + 2;     // sum of three terms
  localparam int RW  = S2W - (QF - 1);  // doubled and rounded rotation offset
  localparam int FW  = ((RW > DW) ? RW : DW) + 2;  // offset + vector + origin

  // Configuration port
  localparam int NREG = 7;
  localparam int PDW  = 32;
  localparam int AW   = $clog2(NREG * 4);
  localparam int IW   = AW - 2;

  localparam logic signed [QW-1:0] QUAT_ONE = QW'(1) << QF;

  typedef enum logic [IW-1:0] {
    REG_QUAT_W   = 3'd0,
    REG_QUAT_X   = 3'd1,
    REG_QUAT_Y   = 3'd2,
    REG_QUAT_Z   = 3'd3,
    REG_ORIGIN_X = 3'd4,
    REG_ORIGIN_Y = 3'd5,
    REG_ORIGIN_Z = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_PT_WORLD  = 2'd0,
    KIND_PT_LOCAL  = 2'd1,
    KIND_DIR_WORLD = 2'd2,
    KIND_DIR_LOCAL = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [QW-1:0] qw;
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] oz;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 saturated;
  } out_item_t;

  // Stage 1: conjugated quaternion and (translated) vector
  typedef struct packed {
    logic [1:0]            kind;
    logic signed [QNW-1:0] qw;
    logic signed [QNW-1:0] qx;
    logic signed [QNW-1:0] qy;
    logic signed [QNW-1:0] qz;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [DW-1:0]  dz;
  } s1_t;

  // Stage 2: u x v partial products
  typedef struct packed {
    logic [1:0]            kind;
    logic signed [QNW-1:0] qw;
    logic signed [QNW-1:0] qx;
    logic signed [QNW-1:0] qy;
    logic signed [QNW-1:0] qz;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [DW-1:0]  dz;
    logic signed [P1W-1:0] c0p;
    logic signed [P1W-1:0] c0n;
    logic signed [P1W-1:0] c1p;
    logic signed [P1W-1:0] c1n;
    logic signed [P1W-1:0] c2p;
    logic signed [P1W-1:0] c2n;
  } s2_t;

  // Stage 3: rounded u x v
  typedef struct packed {
    logic [1:0]            kind;
    logic signed [QNW-1:0] qw;
    logic signed [QNW-1:0] qx;
    logic signed [QNW-1:0] qy;
    logic signed [QNW-1:0] qz;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [DW-1:0]  dz;
    logic signed [UW-1:0]  u0;
    logic signed [UW-1:0]  u1;
    logic signed [UW-1:0]  u2;
  } s3_t;

  // Stage 4: w*(u x v) + u x (u x v) partial products
  typedef struct packed {
    logic [1:0]            kind;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [DW-1:0]  dz;
    logic signed [P2W-1:0] a0w;
    logic signed [P2W-1:0] a0p;
    logic signed [P2W-1:0] a0n;
    logic signed [P2W-1:0] a1w;
    logic signed [P2W-1:0] a1p;
    logic signed [P2W-1:0] a1n;
    logic signed [P2W-1:0] a2w;
    logic signed [P2W-1:0] a2p;
    logic signed [P2W-1:0] a2n;
  } s4_t;

  // Stage 5: rotation offsets, ready for translation
  typedef struct packed {
    logic [1:0]           kind;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
    logic signed [RW-1:0] r0;
    logic signed [RW-1:0] r1;
    logic signed [RW-1:0] r2;
  } s5_t;

  // Exact quaternion by vector product
  function automatic logic signed [P1W-1:0] mul_qd(logic signed [QNW-1:0] a,
                                                  logic signed [DW-1:0] b);
    return a * b;
  endfunction

  // Exact quaternion by u x v product
  function automatic logic signed [P2W-1:0] mul_qu(logic signed [QNW-1:0] a,
                                                  logic signed [UW-1:0] b);
    return a * b;
  endfunction

  // Round half up to coordinate units
  function automatic logic signed [UW-1:0] rnd_cross(logic signed [S1W-1:0] s);
    logic [S1W-1:0] t;
    t = s + (S1W'(1) << (QF - 1));
    return t[S1W-1:QF];
  endfunction

  // Double and round half up in one step
  function automatic logic signed [RW-1:0] rnd_twist(logic signed [S2W-1:0] s);
    logic [S2W-1:0] t;
    t = s + (S2W'(1) << (QF - 2));
    return t[S2W-1:QF-1];
  endfunction

endpackage

FILE: rtl/core/qrt_cfg.sv
`timescale 1ns / 1ps
// APB register file: quaternion and frame origin.
// Depends on qrt_pkg.
module qrt_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qrt_pkg::AW-1:0]     paddr,
  input  logic [qrt_pkg::PDW-1:0]    pwdata,
  output logic [qrt_pkg::PDW-1:0]    prdata,
  output logic                       pready,
  output qrt_pkg::cfg_t              cfg
);
  import qrt_pkg::*;

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.qw <= QUAT_ONE;
      regs.qx <= '0;
      regs.qy <= '0;
      regs.qz <= '0;
      regs.ox <= '0;
      regs.oy <= '0;
      regs.oz <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_QUAT_W:   regs.qw <= pwdata[QW-1:0];
        REG_QUAT_X:   regs.qx <= pwdata[QW-1:0];
        REG_QUAT_Y:   regs.qy <= pwdata[QW-1:0];
        REG_QUAT_Z:   regs.qz <= pwdata[QW-1:0];
        REG_ORIGIN_X: regs.ox <= pwdata[CW-1:0];
        REG_ORIGIN_Y: regs.oy <= pwdata[CW-1:0];
        REG_ORIGIN_Z: regs.oz <= pwdata[CW-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // read-back, sign extended
  always_comb begin
    unique case (idx)
      REG_QUAT_W:   prdata = PDW'(regs.qw);
      REG_QUAT_X:   prdata = PDW'(regs.qx);
      REG_QUAT_Y:   prdata = PDW'(regs.qy);
      REG_QUAT_Z:   prdata = PDW'(regs.qz);
      REG_ORIGIN_X: prdata = PDW'(regs.ox);
      REG_ORIGIN_Y: prdata = PDW'(regs.oy);
      REG_ORIGIN_Z: prdata = PDW'(regs.oz);
      default:      prdata = '0;
    endcase
  end

  ap_reset_identity: assert property (@(posedge clk)
    $past(rst) |-> (regs.qw == QUAT_ONE && regs.qx == '0 && regs.ox == '0))
    else $error("registers not at reset values after reset");

  ap_origin_write: assert property (@(posedge clk) disable iff (rst)
    (wr && idx == REG_ORIGIN_X) |=> (regs.ox == $past(pwdata[CW-1:0])))
    else $error("origin x write not taken");

endmodule

FILE: rtl/core/qrt_cross.sv
`timescale 1ns / 1ps
// Pipeline stages 1-3: conjugation and point-to-local translation, u x v
// products, rounding of u x v. Depends on qrt_pkg.
module qrt_cross (
  input  logic                 clk,
  input  logic                 rst,
  input  qrt_pkg::cfg_t        cfg,
  input  logic                 up_valid,
  input  qrt_pkg::in_item_t    up_data,
  output logic                 up_ready,
  output logic                 dn_valid,
  output qrt_pkg::s3_t         dn_data,
  input  logic                 dn_ready
);
  import qrt_pkg::*;

  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;
  logic v1, v2, v3;
  logic take1, take2, take3;
  logic conj, to_local;

  // a stage loads when empty or when its contents move on
  assign take3    = !v3 || dn_ready;
  assign take2    = !v2 || take3;
  assign take1    = !v1 || take2;
  assign up_ready = take1;
  assign dn_valid = v3;
  assign dn_data  = s3;

  // stage 1: conjugate for local kinds, subtract origin for point to local
  assign conj     = (up_data.kind == KIND_PT_LOCAL) || (up_data.kind == KIND_DIR_LOCAL);
  assign to_local = (up_data.kind == KIND_PT_LOCAL);

  always_comb begin
    s1_next.kind = up_data.kind;
    s1_next.qw   = QNW'(cfg.qw);
    s1_next.qx   = conj ? -QNW'(cfg.qx) : QNW'(cfg.qx);
    s1_next.qy   = conj ? -QNW'(cfg.qy) : QNW'(cfg.qy);
    s1_next.qz   = conj ? -QNW'(cfg.qz) : QNW'(cfg.qz);
    s1_next.dx   = to_local ? DW'(up_data.in_x) - DW'(cfg.ox) : DW'(up_data.in_x);
    s1_next.dy   = to_local ? DW'(up_data.in_y) - DW'(cfg.oy) : DW'(up_data.in_y);
    s1_next.dz   = to_local ? DW'(up_data.in_z) - DW'(cfg.oz) : DW'(up_data.in_z);
  end

  // stage 2: six products of u x v
  always_comb begin
    s2_next.kind = s1.kind;
    s2_next.qw   = s1.qw;
    s2_next.qx   = s1.qx;
    s2_next.qy   = s1.qy;
    s2_next.qz   = s1.qz;
    s2_next.dx   = s1.dx;
    s2_next.dy   = s1.dy;
    s2_next.dz   = s1.dz;
    s2_next.c0p  = mul_qd(s1.qy, s1.dz);
    s2_next.c0n  = mul_qd(s1.qz, s1.dy);
    s2_next.c1p  = mul_qd(s1.qz, s1.dx);
    s2_next.c1n  = mul_qd(s1.qx, s1.dz);
    s2_next.c2p  = mul_qd(s1.qx, s1.dy);
    s2_next.c2n  = mul_qd(s1.qy, s1.dx);
  end

  // stage 3: differences, rounded to coordinate units
  always_comb begin
    s3_next.kind = s2.kind;
    s3_next.qw   = s2.qw;
    s3_next.qx   = s2.qx;
    s3_next.qy   = s2.qy;
    s3_next.qz   = s2.qz;
    s3_next.dx   = s2.dx;
    s3_next.dy   = s2.dy;
    s3_next.dz   = s2.dz;
    s3_next.u0   = rnd_cross(S1W'(s2.c0p) - S1W'(s2.c0n));
    s3_next.u1   = rnd_cross(S1W'(s2.c1p) - S1W'(s2.c1n));
    s3_next.u2   = rnd_cross(S1W'(s2.c2p) - S1W'(s2.c2n));
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (take1) v1 <= up_valid;
      if (take2) v2 <= v1;
      if (take3) v3 <= v2;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take1) s1 <= s1_next;
    if (take2) s2 <= s2_next;
    if (take3) s3 <= s3_next;
  end

  ap_hold_stage1: assert property (@(posedge clk) disable iff (rst)
    (v1 && !take2) |=> (v1 && $stable(s1)))
    else $error("stalled stage 1 item lost or changed");

endmodule

FILE: rtl/core/qrt_twist.sv
`timescale 1ns / 1ps
// Pipeline stages 4-5: w*(u x v) + u x (u x v) products, then the sum
// doubled and rounded. Depends on qrt_pkg.
module qrt_twist (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  qrt_pkg::s3_t  up_data,
  output logic          up_ready,
  output logic          dn_valid,
  output qrt_pkg::s5_t  dn_data,
  input  logic          dn_ready
);
  import qrt_pkg::*;

  s4_t  s4, s4_next;
  s5_t  s5, s5_next;
  logic v4, v5;
  logic take4, take5;

  assign take5    = !v5 || dn_ready;
  assign take4    = !v4 || take5;
  assign up_ready = take4;
  assign dn_valid = v5;
  assign dn_data  = s5;

  // stage 4: nine products
  always_comb begin
    s4_next.kind = up_data.kind;
    s4_next.dx   = up_data.dx;
    s4_next.dy   = up_data.dy;
    s4_next.dz   = up_data.dz;
    s4_next.a0w  = mul_qu(up_data.qw, up_data.u0);
    s4_next.a0p  = mul_qu(up_data.qy, up_data.u2);
    s4_next.a0n  = mul_qu(up_data.qz, up_data.u1);
    s4_next.a1w  = mul_qu(up_data.qw, up_data.u1);
    s4_next.a1p  = mul_qu(up_data.qz, up_data.u0);
    s4_next.a1n  = mul_qu(up_data.qx, up_data.u2);
    s4_next.a2w  = mul_qu(up_data.qw, up_data.u2);
    s4_next.a2p  = mul_qu(up_data.qx, up_data.u1);
    s4_next.a2n  = mul_qu(up_data.qy, up_data.u0);
  end

  // stage 5: exact three-term sum, then x2 with rounding
  always_comb begin
    s5_next.kind = s4.kind;
    s5_next.dx   = s4.dx;
    s5_next.dy   = s4.dy;
    s5_next.dz   = s4.dz;
    s5_next.r0   = rnd_twist(S2W'(s4.a0w) + S2W'(s4.a0p) - S2W'(s4.a0n));
    s5_next.r1   = rnd_twist(S2W'(s4.a1w) + S2W'(s4.a1p) - S2W'(s4.a1n));
    s5_next.r2   = rnd_twist(S2W'(s4.a2w) + S2W'(s4.a2p) - S2W'(s4.a2n));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (take4) v4 <= up_valid;
      if (take5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (take4) s4 <= s4_next;
    if (take5) s5 <= s5_next;
  end

endmodule

FILE: rtl/core/qrt_finish.sv
`timescale 1ns / 1ps
// Pipeline stage 6: add the vector and, for point to world, the origin;
// saturate and hold in the output register. Depends on qrt_pkg.
module qrt_finish (
  input  logic                clk,
  input  logic                rst,
  input  qrt_pkg::cfg_t       cfg,
  input  logic                up_valid,
  input  qrt_pkg::s5_t        up_data,
  output logic                up_ready,
  output logic                out_valid,
  output qrt_pkg::out_item_t  out_data,
  input  logic                out_stall
);
  import qrt_pkg::*;

  localparam logic signed [FW-1:0] COORD_MAX = (FW'(1) << (CW - 1)) - FW'(1);
  localparam logic signed [FW-1:0] COORD_MIN = ~COORD_MAX;
  localparam logic signed [CW-1:0] OUT_MAX   = COORD_MAX[CW-1:0];
  localparam logic signed [CW-1:0] OUT_MIN   = COORD_MIN[CW-1:0];

  out_item_t            out_next;
  logic                 take6;
  logic                 add_org;
  logic signed [DW-1:0] d_a [3];
  logic signed [RW-1:0] r_a [3];
  logic signed [CW-1:0] o_a [3];
  logic signed [CW-1:0] res [3];
  logic [2:0]           clip;

  assign take6    = !out_valid || !out_stall;
  assign up_ready = take6;
  assign add_org  = (up_data.kind == KIND_PT_WORLD);

  assign d_a[0] = up_data.dx;
  assign d_a[1] = up_data.dy;
  assign d_a[2] = up_data.dz;
  assign r_a[0] = up_data.r0;
  assign r_a[1] = up_data.r1;
  assign r_a[2] = up_data.r2;
  assign o_a[0] = cfg.ox;
  assign o_a[1] = cfg.oy;
  assign o_a[2] = cfg.oz;

  // per component: vector + offset (+ origin), clipped to the coordinate range
  always_comb begin
    logic signed [FW-1:0] org_term;
    logic signed [FW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      org_term = add_org ? FW'(o_a[i]) : FW'(0);
      sum      = FW'(d_a[i]) + FW'(r_a[i]) + org_term;
      if (sum > COORD_MAX) begin
        res[i]  = OUT_MAX;
        clip[i] = 1'b1;
      end else if (sum < COORD_MIN) begin
        res[i]  = OUT_MIN;
        clip[i] = 1'b1;
      end else begin
        res[i]  = sum[CW-1:0];
        clip[i] = 1'b0;
      end
    end
    out_next.out_x     = res[0];
    out_next.out_y     = res[1];
    out_next.out_z     = res[2];
    out_next.saturated = |clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take6) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take6) out_data <= out_next;
  end

  ap_sat_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.saturated) |->
      (out_data.out_x == OUT_MAX || out_data.out_x == OUT_MIN ||
       out_data.out_y == OUT_MAX || out_data.out_y == OUT_MIN ||
       out_data.out_z == OUT_MAX || out_data.out_z == OUT_MIN))
    else $error("saturated flag with no clipped component");

endmodule

FILE: rtl/core/quaternion_rigid_transform_top.sv
`timescale 1ns / 1ps
// Top level of the quaternion rigid transform: register file and pipeline.
// Depends on qrt_pkg, qrt_cfg, qrt_cross, qrt_twist, qrt_finish.
//
//   channel  | ports                                    | direction
//   ---------+------------------------------------------+----------------------
//   input    | in_valid, in_stall, in_data (in_item_t)  | kind + vector in
//   output   | out_valid, out_stall, out_data            | transformed vector out
//   config   | psel, penable, pwrite, paddr, pwdata,    | quaternion and origin
//            | prdata, pready                           | registers
//
// One transaction per cycle sustained while out_stall is low. Six register
// stages (origin subtract, two multiplier stages, their two rounding stages,
// output register), the first loaded at acceptance.
// Synchronous active-high reset empties the pipeline and loads the identity
// quaternion and zero origin.
// Stalls collapse bubbles: a stage fills whenever it is empty, so in_stall rises
// only once every stage holds a transaction and out_stall is high.
module quaternion_rigid_transform_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  qrt_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output qrt_pkg::out_item_t        out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [qrt_pkg::AW-1:0]    paddr,
  input  logic [qrt_pkg::PDW-1:0]   pwdata,
  output logic [qrt_pkg::PDW-1:0]   prdata,
  output logic                      pready
);
  import qrt_pkg::*;

  cfg_t cfg;
  s3_t  cross_data;
  s5_t  twist_data;
  logic cross_ready, cross_valid;
  logic twist_ready, twist_valid;
  logic finish_ready;

  assign in_stall = !cross_ready;

  qrt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qrt_cross u_cross (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_ready (cross_ready),
    .dn_valid (cross_valid),
    .dn_data  (cross_data),
    .dn_ready (twist_ready)
  );

  qrt_twist u_twist (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cross_valid),
    .up_data  (cross_data),
    .up_ready (twist_ready),
    .dn_valid (twist_valid),
    .dn_data  (twist_data),
    .dn_ready (finish_ready)
  );

  qrt_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .up_valid  (twist_valid),
    .up_data   (twist_data),
    .up_ready  (finish_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

FILE: test/quaternion_rigid_transform_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_rigid_transform_top: loads frames over the
// APB port, streams vectors of all four kinds and checks each result against a predictor.
// Depends on qrt_pkg and the RTL under rtl/core.
module quaternion_rigid_transform_top_tb;
  import qrt_pkg::*;

  // Expected-result store plus its own copy of the frame registers
  class transform_checker;
    cfg_t      frame;
    out_item_t expected_vecs[$];
    int        errors;
    int        checked;
    int        saturations;
    int        kind_count[4];

    function new();
      reset_frame();
    endfunction

    function void reset_frame();
      frame    = '0;
      frame.qw = QUAT_ONE;
    endfunction

    // Writes beyond the register list are dropped
    function void write_reg(int idx, logic [PDW-1:0] value);
      if (idx >= NREG) return;
      case (reg_idx_t'(idx))
        REG_QUAT_W:   frame.qw = value[QW-1:0];
        REG_QUAT_X:   frame.qx = value[QW-1:0];
        REG_QUAT_Y:   frame.qy = value[QW-1:0];
        REG_QUAT_Z:   frame.qz = value[QW-1:0];
        REG_ORIGIN_X: frame.ox = value[CW-1:0];
        REG_ORIGIN_Y: frame.oy = value[CW-1:0];
        REG_ORIGIN_Z: frame.oz = value[CW-1:0];
        default: ;
      endcase
    endfunction

    // Round half up, arithmetic shift
    function longint round_shift(longint s, int sh);
      return (s + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // v' = v + 2*(w*(u x v) + u x (u x v)), then translate and clip
    function out_item_t rotate_translate(in_item_t it);
      longint    w, x, y, z, lim;
      longint    v[3], o[3], u[3], a[3], r[3];
      out_item_t res;
      int        i;
      w = frame.qw;
      x = frame.qx;
      y = frame.qy;
      z = frame.qz;
      o[0] = frame.ox;
      o[1] = frame.oy;
      o[2] = frame.oz;
      v[0] = it.in_x;
      v[1] = it.in_y;
      v[2] = it.in_z;
      // local kinds use the conjugate; point to local subtracts the origin first
      if (it.kind[0]) begin
        x = -x;
        y = -y;
        z = -z;
      end
      if (it.kind == KIND_PT_LOCAL) begin
        for (i = 0; i < 3; i++) v[i] = v[i] - o[i];
      end
      u[0] = round_shift(y * v[2] - z * v[1], QF);
      u[1] = round_shift(z * v[0] - x * v[2], QF);
      u[2] = round_shift(x * v[1] - y * v[0], QF);
      a[0] = w * u[0] + y * u[2] - z * u[1];
      a[1] = w * u[1] + z * u[0] - x * u[2];
      a[2] = w * u[2] + x * u[1] - y * u[0];
      lim = longint'(1) <<< (CW - 1);
      res.saturated = 1'b0;
      for (i = 0; i < 3; i++) begin
        r[i] = v[i] + round_shift(a[i], QF - 1);
        if (it.kind == KIND_PT_WORLD) r[i] = r[i] + o[i];
        if (r[i] > lim - 1) begin
          r[i] = lim - 1;
          res.saturated = 1'b1;
        end
        if (r[i] < -lim) begin
          r[i] = -lim;
          res.saturated = 1'b1;
        end
      end
      res.out_x = CW'(r[0]);
      res.out_y = CW'(r[1]);
      res.out_z = CW'(r[2]);
      return res;
    endfunction

    function void note_input(in_item_t it);
      expected_vecs.push_back(rotate_translate(it));
      kind_count[it.kind]++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_vecs.size() == 0) begin
        report($sformatf("result with nothing outstanding: x=%0d y=%0d z=%0d",
                         got.out_x, got.out_y, got.out_z));
        return;
      end
      want = expected_vecs.pop_front();
      checked++;
      if (want.saturated) saturations++;
      if (got.out_x !== want.out_x)
        report($sformatf("out_x #%0d: got %0d, expected %0d", checked, got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
        report($sformatf("out_y #%0d: got %0d, expected %0d", checked, got.out_y, want.out_y));
      if (got.out_z !== want.out_z)
        report($sformatf("out_z #%0d: got %0d, expected %0d", checked, got.out_z, want.out_z));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated #%0d: got %0b, expected %0b", checked, got.saturated,
                         want.saturated));
    endtask
  endclass

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_stall;
  out_item_t       out_data;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [AW-1:0]   paddr;
  logic [PDW-1:0]  pwdata;
  logic [PDW-1:0]  prdata;
  logic            pready;
  bit              quiet;
  transform_checker sb = new();

  quaternion_rigid_transform_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Full-range and moderate coordinates alike, with wider values and extremes mixed in
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return CW'(int'($urandom_range(2097151)) - 1048576);
      8:          return CW'(int'($urandom_range(536870911)) - 268435456);
      default: begin
        case ($urandom_range(3))
          0:       return {1'b0, {(CW-1){1'b1}}};
          1:       return {1'b1, {(CW-1){1'b0}}};
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Common rotation components, otherwise any 18-bit value
  function automatic logic [QW-1:0] rand_quat_part();
    case ($urandom_range(7))
      0:       return '0;
      1:       return QW'(46341);
      2:       return QW'(-46341);
      3:       return QW'(32768);
      4:       return QW'(-32768);
      5:       return QUAT_ONE;
      6:       return -QUAT_ONE;
      default: return QW'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_vector();
    in_item_t it;
    it.kind = kind_t'($urandom_range(3));
    it.in_x = rand_coord();
    it.in_y = rand_coord();
    it.in_z = rand_coord();
    return it;
  endfunction

  // Entered and left just after a falling edge
  task automatic push_vector(in_item_t it);
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // APB setup then access phase
  task automatic write_reg_port(int idx, logic [PDW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(idx * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Quaternion writes carry junk above bit 17, which the block must drop
  task automatic load_frame(cfg_t f);
    logic [PDW-1:0] d;
    d = $urandom;
    d[QW-1:0] = f.qw;
    write_reg_port(REG_QUAT_W, d);
    d = $urandom;
    d[QW-1:0] = f.qx;
    write_reg_port(REG_QUAT_X, d);
    d = $urandom;
    d[QW-1:0] = f.qy;
    write_reg_port(REG_QUAT_Y, d);
    d = $urandom;
    d[QW-1:0] = f.qz;
    write_reg_port(REG_QUAT_Z, d);
    write_reg_port(REG_ORIGIN_X, f.ox);
    write_reg_port(REG_ORIGIN_Y, f.oy);
    write_reg_port(REG_ORIGIN_Z, f.oz);
  endtask

  // Hold the sender off until every outstanding transaction is back
  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (sb.expected_vecs.size() != 0 && n < 10000) begin
      @(negedge clk);
      n++;
    end
    if (sb.expected_vecs.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.expected_vecs.size()));
      sb.expected_vecs.delete();
    end
    repeat (10) @(negedge clk);
  endtask

  // Each kind with full-scale coordinates of both signs
  task automatic directed_sweep();
    kind_t    kinds[4];
    in_item_t it;
    kinds = '{KIND_PT_WORLD, KIND_PT_LOCAL, KIND_DIR_WORLD, KIND_DIR_LOCAL};
    foreach (kinds[k]) begin
      it.kind = kinds[k];
      it.in_x = {1'b0, {(CW-1){1'b1}}};
      it.in_y = {1'b1, {(CW-1){1'b0}}};
      it.in_z = '0;
      push_vector(it);
      it.in_x = {1'b1, {(CW-1){1'b0}}};
      it.in_y = '1;
      it.in_z = CW'(32'h0000_8000);
      push_vector(it);
    end
  endtask

  // Receiver stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !quiet && ($urandom_range(99) < 7);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    #3_000_000;
    $display("quaternion_rigid_transform_top_tb: done, errors");
    $finish;
  end

  initial begin
    cfg_t f;
    int   ph;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    quiet    = 1'b0;
    rst      = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset frame: identity rotation, zero origin
    directed_sweep();
    drain();

    // Largest quaternion and origin: heavy overflow in every kind
    f.qw = {1'b0, {(QW-1){1'b1}}};
    f.qx = {1'b0, {(QW-1){1'b1}}};
    f.qy = {1'b0, {(QW-1){1'b1}}};
    f.qz = {1'b0, {(QW-1){1'b1}}};
    f.ox = {1'b0, {(CW-1){1'b1}}};
    f.oy = {1'b0, {(CW-1){1'b1}}};
    f.oz = {1'b0, {(CW-1){1'b1}}};
    load_frame(f);
    directed_sweep();
    drain();

    // Most negative everything; conjugation then needs the extra bit
    f.qw = {1'b1, {(QW-1){1'b0}}};
    f.qx = {1'b1, {(QW-1){1'b0}}};
    f.qy = {1'b1, {(QW-1){1'b0}}};
    f.qz = {1'b1, {(QW-1){1'b0}}};
    f.ox = {1'b1, {(CW-1){1'b0}}};
    f.oy = {1'b1, {(CW-1){1'b0}}};
    f.oz = {1'b1, {(CW-1){1'b0}}};
    load_frame(f);
    write_reg_port(NREG, $urandom);
    directed_sweep();
    drain();

    // Random frames, one phase with no idling on either side
    for (ph = 0; ph < 8; ph++) begin
      quiet = (ph == 2);
      f.qw = rand_quat_part();
      f.qx = rand_quat_part();
      f.qy = rand_quat_part();
      f.qz = rand_quat_part();
      f.ox = $urandom_range(1) ? rand_coord() : '0;
      f.oy = $urandom_range(1) ? rand_coord() : '0;
      f.oz = $urandom_range(1) ? rand_coord() : '0;
      load_frame(f);
      if ($urandom_range(3) == 0) write_reg_port(NREG, $urandom);
      repeat (250) push_vector(random_vector());
      drain();
    end
    quiet = 1'b0;

    $display("Checked %0d transforms over 11 frame settings, %0d of them clipped.",
             sb.checked, sb.saturations);
    $display("By kind: point->world %0d, point->local %0d, dir->world %0d, dir->local %0d.",
             sb.kind_count[KIND_PT_WORLD], sb.kind_count[KIND_PT_LOCAL],
             sb.kind_count[KIND_DIR_WORLD], sb.kind_count[KIND_DIR_LOCAL]);
    if (sb.errors == 0) begin
      $display("quaternion_rigid_transform_top_tb: done, clean");
    end else begin
      $display("quaternion_rigid_transform_top_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/qrt_pkg.sv
rtl/core/qrt_cfg.sv
rtl/core/qrt_cross.sv
rtl/core/qrt_twist.sv
rtl/core/qrt_finish.sv
rtl/core/quaternion_rigid_transform_top.sv
test/quaternion_rigid_transform_top_tb.sv
